// ----- src/dfr_pkg.sv -----
// Shared constants and types for the delimited frame receiver.
`default_nettype none

package dfr_pkg;

	localparam logic [7:0]  CH_LEAD          = 8'h21;  // '!'
	localparam logic [7:0]  CH_OPEN          = 8'h26;  // '&'
	localparam logic [7:0]  CH_CLOSE         = 8'h23;  // '#'
	localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;

	// result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// byte held in the input stage
	typedef struct packed {
		logic       vld;
		logic [7:0] data;
	} rx_stage_t;

endpackage

`default_nettype wire

// ----- src/delimited_frame_receiver.sv -----
// Path: a transferred byte is held in the input register, then its result is loaded into the
// result register and offered at the output; bytes that produce no result vanish.
// Throughput: one byte per clock while the result register is free or being taken.
// The output register is freed and refilled in the same cycle, so a stalled consumer
// only holds the input once both registers are full.
// Reset: hunting for the start pair, stored count zero, max_length 65535; no clearing pass.
`default_nettype none

module delimited_frame_receiver import dfr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] max_length,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             out_kind,
	output logic [1:0]       n_bytes,
	output logic [7:0]       byte_a,
	output logic [7:0]       byte_b,
	output logic [15:0]      write_index
);

	logic [15:0] max_len_q;
	rx_stage_t   stage_s1;
	logic        advance;

	// capacity register, written on any configuration transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= max_length;
		end
	end

	dfr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.stage_s1 (stage_s1)
	);

	dfr_deframer u_deframer (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage_s1    (stage_s1),
		.advance     (advance),
		.max_len     (max_len_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_kind    (out_kind),
		.n_bytes     (n_bytes),
		.byte_a      (byte_a),
		.byte_b      (byte_b),
		.write_index (write_index)
	);

endmodule

`default_nettype wire

// ----- src/dfr_in_reg.sv -----
// Input register stage: holds one received byte until the deframer takes it.
`default_nettype none

module dfr_in_reg import dfr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output rx_stage_t       stage_s1
);

	logic       vld_q;
	logic [7:0] data_q;

	// take a new byte whenever the held one is empty or leaving
	assign in_ready = !vld_q || advance;

	// load on transfer, clear when the held byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= rx_byte;
		end
	end

	assign stage_s1.vld  = vld_q;
	assign stage_s1.data = data_q;

endmodule

`default_nettype wire

// ----- src/dfr_deframer.sv -----
// Deframing state machine and result register.
`default_nettype none

module dfr_deframer import dfr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rx_stage_t   stage_s1,
	output logic             advance,
	input  wire logic [15:0] max_len,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             out_kind,
	output logic [1:0]       n_bytes,
	output logic [7:0]       byte_a,
	output logic [7:0]       byte_b,
	output logic [15:0]      write_index
);

	typedef enum logic [1:0] {
		HUNT1 = 2'd0,
		HUNT2 = 2'd1,
		RECV  = 2'd2,
		STOP1 = 2'd3
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic        res_vld;
	logic        res_kind;
	logic [1:0]  res_n;
	logic [7:0]  res_a, res_b;
	logic        fit_one, fit_two;
	logic        out_vld_q;
	logic        take;

	// the result register is free when empty or being taken
	assign advance = !out_vld_q || out_ready;
	assign take    = stage_s1.vld && advance;

	assign fit_one = count_q < max_len;
	assign fit_two = ({1'b0, count_q} + 17'd2) <= {1'b0, max_len};

	// work out the next state and the result for the held byte
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		res_vld  = 1'b0;
		res_kind = KIND_DATA;
		res_n    = 2'd0;
		res_a    = 8'd0;
		res_b    = 8'd0;
		unique case (phase_q)
			HUNT1: begin
				if (stage_s1.data == CH_LEAD) phase_d = HUNT2;
			end
			HUNT2: begin
				phase_d = (stage_s1.data == CH_OPEN) ? RECV : HUNT1;
			end
			RECV: begin
				if (stage_s1.data == CH_LEAD) begin
					phase_d = STOP1;
				end else if (fit_one) begin
					count_d = count_q + 16'd1;
					res_vld = 1'b1;
					res_n   = 2'd1;
					res_a   = stage_s1.data;
				end
			end
			STOP1: begin
				if (stage_s1.data == CH_LEAD) begin
					// doubled lead: one '!' stored, stay after a lead
					if (fit_one) begin
						count_d = count_q + 16'd1;
						res_vld = 1'b1;
						res_n   = 2'd1;
						res_a   = CH_LEAD;
					end
				end else if (stage_s1.data == CH_CLOSE) begin
					phase_d  = HUNT1;
					count_d  = 16'd0;
					res_vld  = 1'b1;
					res_kind = KIND_END;
				end else begin
					// lead plus byte: keep only if both fit
					phase_d = RECV;
					if (fit_two) begin
						count_d = count_q + 16'd2;
						res_vld = 1'b1;
						res_n   = 2'd2;
						res_a   = CH_LEAD;
						res_b   = stage_s1.data;
					end
				end
			end
			default: phase_d = HUNT1;
		endcase
	end

	// hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= HUNT1;
			count_q   <= 16'd0;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				count_q <= count_d;
			end
			if (advance) begin
				out_vld_q <= take && res_vld;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take && res_vld) begin
			out_kind    <= res_kind;
			n_bytes     <= res_n;
			byte_a      <= res_a;
			byte_b      <= res_b;
			write_index <= count_q;
		end
	end

	assign out_valid = out_vld_q;

	a_end_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res_vld && res_kind == KIND_END) |=> (phase_q == HUNT1 && count_q == 16'd0))
		else $error("frame end did not rearm the receiver");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res_vld && res_kind == KIND_DATA)
			|=> (count_q == $past(count_q) + {14'd0, $past(res_n)}))
		else $error("stored count did not advance by the bytes sent");

	a_kind_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ((out_kind == KIND_END) == (n_bytes == 2'd0)))
		else $error("result kind and byte count disagree");

	a_byte_b_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && n_bytes != 2'd2) |-> (byte_b == 8'd0))
		else $error("second byte set on a short result");

	a_no_data_in_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (phase_q == HUNT1 || phase_q == HUNT2)) |-> !res_vld)
		else $error("result produced while hunting for a frame");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the delimited frame receiver: directed and random framed streams, stalls.
`timescale 1ns / 1ps

// Phase of the deframer as tracked alongside the block
typedef enum logic [1:0] {
	HUNT_LEAD,
	HUNT_OPEN,
	IN_FRAME,
	AFTER_LEAD
} deframe_phase_t;

typedef struct packed {
	logic        kind;
	logic [1:0]  nb;
	logic [7:0]  first;
	logic [7:0]  second;
	logic [15:0] idx;
} deframe_result_t;

// Tracks the frame state and the queue of results still owed by the block
class frame_tracker;
	logic [15:0]     capacity;
	deframe_phase_t  phase;
	logic [15:0]     stored;
	deframe_result_t owed_results[$];
	int              mismatches;

	function new();
		capacity = dfr_pkg::MAX_LENGTH_RESET;
		phase = HUNT_LEAD;
		stored = '0;
		mismatches = 0;
	endfunction

	function void set_capacity(logic [15:0] v);
		capacity = v;
	endfunction

	function int outstanding();
		return owed_results.size();
	endfunction

	function void owe(logic kind, logic [1:0] nb, logic [7:0] a, logic [7:0] b,
			logic [15:0] idx);
		deframe_result_t r;
		r.kind = kind;
		r.nb = nb;
		r.first = a;
		r.second = b;
		r.idx = idx;
		owed_results.push_back(r);
	endfunction

	// Advance the frame state by one transferred byte; return 0 if it was ignored
	function bit take_byte(logic [7:0] c);
		logic [15:0] idx;
		idx = stored;
		case (phase)
			HUNT_LEAD: begin
				if (c != dfr_pkg::CH_LEAD)
					return 1'b0;
				phase = HUNT_OPEN;
			end
			HUNT_OPEN: begin
				phase = (c == dfr_pkg::CH_OPEN) ? IN_FRAME : HUNT_LEAD;
			end
			IN_FRAME: begin
				if (c == dfr_pkg::CH_LEAD) begin
					phase = AFTER_LEAD;
				end else if (idx < capacity) begin
					stored = idx + 16'd1;
					owe(dfr_pkg::KIND_DATA, 2'd1, c, 8'h00, idx);
				end
			end
			default: begin
				if (c == dfr_pkg::CH_LEAD) begin
					// doubled lead: one lead stored, still after a lead
					if (idx < capacity) begin
						stored = idx + 16'd1;
						owe(dfr_pkg::KIND_DATA, 2'd1, dfr_pkg::CH_LEAD, 8'h00, idx);
					end
				end else if (c == dfr_pkg::CH_CLOSE) begin
					phase = HUNT_LEAD;
					stored = '0;
					owe(dfr_pkg::KIND_END, 2'd0, 8'h00, 8'h00, idx);
				end else begin
					// lead plus byte: stored only if both fit
					phase = IN_FRAME;
					if ({1'b0, idx} + 17'd2 <= {1'b0, capacity}) begin
						stored = idx + 16'd2;
						owe(dfr_pkg::KIND_DATA, 2'd2, dfr_pkg::CH_LEAD, c, idx);
					end
				end
			end
		endcase
		return 1'b1;
	endfunction

	task report(string what, int got, int want);
		$display("mismatch: %s got %0d want %0d", what, got, want);
		mismatches++;
	endtask

	// Compare one transferred result with the oldest owed one
	task check_result(deframe_result_t got);
		deframe_result_t want;
		if (owed_results.size() == 0) begin
			report("unexpected result, write_index", got.idx, -1);
			return;
		end
		want = owed_results.pop_front();
		if (got.kind != want.kind)
			report("out_kind", got.kind, want.kind);
		if (got.nb != want.nb)
			report("n_bytes", got.nb, want.nb);
		if (got.first != want.first)
			report("byte_a", got.first, want.first);
		if (got.second != want.second)
			report("byte_b", got.second, want.second);
		if (got.idx != want.idx)
			report("write_index", got.idx, want.idx);
	endtask
endclass

module tb;
	import dfr_pkg::*;

	localparam int CYCLE_LIMIT  = 250000;
	localparam int RANDOM_ITEMS = 850;
	localparam int RANDOM_PARTS = 8;
	localparam int HOLD_CYCLES  = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] max_length = 16'hFFFF;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        out_kind;
	logic [1:0]  n_bytes;
	logic [7:0]  byte_a;
	logic [7:0]  byte_b;
	logic [15:0] write_index;

	frame_tracker tracker = new();
	logic [7:0]   rx_stream[$];
	int           cycles = 0;
	int           live_bytes = 0;
	bit           send_burst = 1'b0;
	bit           sink_burst = 1'b0;
	bit           hold_on = 1'b0;

	delimited_frame_receiver uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.max_length  (max_length),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_kind    (out_kind),
		.n_bytes     (n_bytes),
		.byte_a      (byte_a),
		.byte_b      (byte_b),
		.write_index (write_index)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Offer one byte after a random gap and hold it until the transfer; call at a falling edge
	task send_rx(input logic [7:0] v);
		int gap;
		gap = (send_burst || hold_on) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= v;
		do @(posedge clk); while (!in_ready);
		if (tracker.take_byte(v))
			live_bytes++;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		@(negedge clk);
	endtask

	task send_stream();
		while (rx_stream.size() > 0)
			send_rx(rx_stream.pop_front());
	endtask

	// Drain the block, then write the capacity register
	task set_capacity(input logic [15:0] v);
		in_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		max_length <= v;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_capacity(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Queue one frame, mostly well formed, now and then broken
	task add_frame();
		int len;
		int pick;
		if ($urandom_range(0, 9) < 2)
			repeat ($urandom_range(1, 3)) rx_stream.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0) begin
			rx_stream.push_back(CH_LEAD);
			rx_stream.push_back($urandom_range(0, 1) ? CH_LEAD : 8'($urandom_range(0, 255)));
		end
		rx_stream.push_back(CH_LEAD);
		rx_stream.push_back(CH_OPEN);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
		repeat (len) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				rx_stream.push_back(CH_LEAD);
				rx_stream.push_back(CH_LEAD);
			end else if (pick == 1) begin
				rx_stream.push_back(CH_LEAD);
				rx_stream.push_back(8'($urandom_range(0, 255)));
			end else begin
				rx_stream.push_back(8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 9) != 0) begin
			rx_stream.push_back(CH_LEAD);
			rx_stream.push_back(CH_CLOSE);
		end
	endtask

	// Take results with random stalls and one long hold-off
	initial begin
		int gap;
		int taken;
		bit held;
		deframe_result_t got;
		taken = 0;
		held = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken == 100 && !held) begin
				held = 1'b1;
				hold_on = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_on = 1'b0;
			end
			gap = sink_burst ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.kind = out_kind;
			got.nb = n_bytes;
			got.first = byte_a;
			got.second = byte_b;
			got.idx = write_index;
			tracker.check_result(got);
			taken++;
			if ($urandom_range(0, 29) == 0)
				sink_burst = !sink_burst;
			@(negedge clk);
		end
	end

	// Stimulus: directed cases, then random frames under several capacities
	initial begin
		logic [15:0] cap;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// failed starts, extremes, doubled lead, pair and single past capacity
		set_capacity(16'd3);
		rx_stream = '{CH_LEAD, CH_LEAD, CH_LEAD, 8'h7F, CH_LEAD, CH_OPEN, 8'h00, 8'hFF,
			CH_LEAD, CH_LEAD, 8'h41, 8'h55, CH_LEAD, CH_CLOSE};
		send_stream();

		// open a frame with an escaped pair, then lower capacity below the count
		set_capacity(16'hFFFF);
		rx_stream = '{CH_LEAD, CH_OPEN, 8'h80, 8'h01, CH_LEAD, CH_OPEN};
		send_stream();
		set_capacity(16'd1);
		rx_stream = '{8'h10, CH_LEAD, CH_CLOSE};
		send_stream();

		// zero capacity: nothing stored, empty frame end
		set_capacity(16'd0);
		rx_stream = '{CH_LEAD, CH_OPEN, 8'h33, CH_LEAD, CH_CLOSE};
		send_stream();

		live_bytes = 0;
		for (int part = 0; part < RANDOM_PARTS; part++) begin
			case (part)
				0: cap = 16'd0;
				1: cap = 16'hFFFF;
				2: cap = 16'd1;
				3: cap = 16'd2;
				5: cap = 16'hFFFF;
				default: cap = 16'($urandom_range(0, 30));
			endcase
			set_capacity(cap);
			while (live_bytes < (part + 1) * RANDOM_ITEMS / RANDOM_PARTS) begin
				if (rx_stream.size() == 0)
					add_frame();
				send_rx(rx_stream.pop_front());
			end
		end

		// drain and let the pipeline settle
		in_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (tracker.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
